// ===== hdl/htint_pkg.sv =====
package htint_pkg;

  localparam int HUE_W   = 16;
  localparam int CNT_W   = 5;
  localparam int FLOOR_W = 12;
  localparam int IDX_W   = 8;
  localparam int QBITS   = 9;

  localparam logic [7:0] BYTE_MAX = 8'd255;

  // configuration register indexes
  localparam logic REG_TINT_COUNT  = 1'b0;
  localparam logic REG_VALUE_FLOOR = 1'b1;

endpackage

// ===== hdl/htint_bdiv.sv =====
module htint_bdiv #(
  parameter int NW = 50
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n_i,
  input  logic [NW-1:0] d_i,
  output logic [7:0]    byte_o
);
  import htint_pkg::*;

  // restoring divide, one quotient bit per stage, MSB first
  logic [NW-1:0]    rem_r [QBITS];
  logic [NW-1:0]    den_r [QBITS];
  logic [QBITS-1:0] q_r   [QBITS];

  logic [NW-1:0]    rem_s [QBITS];
  logic [NW-1:0]    den_s [QBITS];
  logic [QBITS-1:0] q_s   [QBITS];

  genvar i;
  generate
    for (i = 0; i < QBITS; i++) begin : g_stage
      logic [NW-1:0]    dsh;
      logic [NW-1:0]    rem_nxt;
      logic [QBITS-1:0] q_nxt;

      if (i == 0) begin : g_src0
        assign rem_s[i] = n_i;
        assign den_s[i] = d_i;
        assign q_s[i]   = '0;
      end else begin : g_srcn
        assign rem_s[i] = rem_r[i-1];
        assign den_s[i] = den_r[i-1];
        assign q_s[i]   = q_r[i-1];
      end

      assign dsh = den_s[i] << (QBITS - 1 - i);

      always_comb begin
        if (rem_s[i] >= dsh) begin
          rem_nxt = rem_s[i] - dsh;
          q_nxt   = {q_s[i][QBITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_s[i];
          q_nxt   = {q_s[i][QBITS-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          den_r[i] <= den_s[i];
          q_r[i]   <= q_nxt;
        end
      end
    end
  endgenerate

  assign byte_o = q_r[QBITS-1][QBITS-1] ? BYTE_MAX : q_r[QBITS-1][7:0];

endmodule

// ===== hdl/hue_rotated_tint.sv =====
// hue_rotated_tint: stateless accent tinter. Each beat carries one RGB accent
// (unsigned fractions of 2^CHANNEL_BITS-1) and a tint index; the block turns it
// into HSV, lifts value to value_floor, rotates hue by
// (tint_index mod tint_count)/tint_count of a turn and rebuilds a packed
// 24-bit RGB byte triple (red 23:16, green 15:8, blue 7:0), rounded exactly.
// Fully pipelined: one beat per cycle while the output is not stalled. The
// pipe holds the hue/rotation dividers (8 stages) and the four byte dividers
// (9 stages, one quotient bit each). A stall at the output freezes the whole
// pipe; in_ready is low only while the output beat waits.
// Config (tint_count index 0, value_floor index 1) is written with cfg_we and
// must only change while no beat is in flight.
module hue_rotated_tint #(
  parameter int CHANNEL_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input beats
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CHANNEL_BITS-1:0]    in_accent_red,
  input  logic [CHANNEL_BITS-1:0]    in_accent_green,
  input  logic [CHANNEL_BITS-1:0]    in_accent_blue,
  input  logic [htint_pkg::IDX_W-1:0] in_tint_index,
  // result beats
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [23:0]                out_packed_rgb,
  // configuration writes
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [htint_pkg::FLOOR_W-1:0] cfg_wdata
);
  import htint_pkg::*;

  localparam int CB         = CHANNEL_BITS;
  localparam int HR_W       = CB + 3;          // hue remainder, < 6*chroma
  localparam int NX_W       = CB + HUE_W;      // channel << 16
  localparam int PX_W       = 2 * CB + HUE_W;  // v * numerator
  localparam int NW         = 2 * CB + 26;     // byte divider dividend
  localparam int FW         = (CB > FLOOR_W) ? CB : FLOOR_W;
  localparam int DIV_STAGES = 8;
  localparam int HUE_STEPS  = 2;               // 16 hue bits over 8 stages
  localparam int ROT_STEPS  = 3;               // 24 rotation bits over 8 stages
  localparam int LANE_STAGES = QBITS;
  localparam int LANES      = 4;
  localparam int LANE_P     = 0;
  localparam int LANE_Q     = 1;
  localparam int LANE_T     = 2;
  localparam int LANE_V     = 3;

  localparam logic [CB-1:0] CMAX = '1;

  // hue sectors
  localparam logic [2:0] SECT_RED_YEL = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG = 3'd4;

  // ---------------------------------------------------------------- config
  logic [CNT_W-1:0]   tint_count_r;
  logic [FLOOR_W-1:0] value_floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_count_r  <= CNT_W'(3);
      value_floor_r <= FLOOR_W'(3481);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TINT_COUNT:  tint_count_r  <= cfg_wdata[CNT_W-1:0];
        REG_VALUE_FLOOR: value_floor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] count_e;
  logic [FW-1:0]    floor_w;
  logic [CB-1:0]    floor_e;

  assign count_e = (tint_count_r == '0) ? CNT_W'(1) : tint_count_r;
  assign floor_w = FW'(value_floor_r);
  assign floor_e = (floor_w > FW'(CMAX)) ? CMAX : floor_w[CB-1:0];

  // --------------------------------------------------------- pipe control
  logic out_vld_r;
  logic adv;

  // whole pipe moves together; it holds only while the output beat waits
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  // -------------------------------------------- stage A: max, min, sector
  logic [CB-1:0]   a_hi, a_lo, a_c, a_v;
  logic [HR_W-1:0] a_num, a_den6;

  always_comb begin
    a_hi = (in_accent_red > in_accent_green) ? in_accent_red : in_accent_green;
    a_lo = (in_accent_red < in_accent_green) ? in_accent_red : in_accent_green;
    if (in_accent_blue > a_hi) a_hi = in_accent_blue;
    if (in_accent_blue < a_lo) a_lo = in_accent_blue;
    a_c  = a_hi - a_lo;
    a_v  = (a_hi > floor_e) ? a_hi : floor_e;
    if (a_c == '0) begin
      // grey: hue stays 0
      a_num  = '0;
      a_den6 = HR_W'(6);
    end else begin
      a_den6 = HR_W'(a_c) * HR_W'(6);
      if (a_hi == in_accent_red) begin
        if (in_accent_green >= in_accent_blue)
          a_num = HR_W'(in_accent_green) - HR_W'(in_accent_blue);
        else
          a_num = a_den6 + HR_W'(in_accent_green) - HR_W'(in_accent_blue);
      end else if (a_hi == in_accent_green) begin
        a_num = HR_W'(in_accent_blue) + (HR_W'(a_c) << 1) - HR_W'(in_accent_red);
      end else begin
        a_num = HR_W'(in_accent_red) + (HR_W'(a_c) << 2) - HR_W'(in_accent_green);
      end
    end
  end

  logic             a_vld_r;
  logic [HR_W-1:0]  a_num_r, a_den6_r;
  logic [CB-1:0]    a_hi_r, a_lo_r, a_c_r, a_v_r;
  logic [IDX_W-1:0] a_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_num_r  <= a_num;
      a_den6_r <= a_den6;
      a_hi_r   <= a_hi;
      a_lo_r   <= a_lo;
      a_c_r    <= a_c;
      a_v_r    <= a_v;
      a_idx_r  <= in_tint_index;
    end
  end

  // ------------------------------------- divide stages: hue and rotation
  // hue = floor(num*2^16 / 6C); rot = low 16 bits of floor(idx*2^16 / count)
  logic             dv_vld_r  [DIV_STAGES];
  logic [HR_W-1:0]  dv_hrem_r [DIV_STAGES];
  logic [HUE_W-1:0] dv_hq_r   [DIV_STAGES];
  logic [HR_W-1:0]  dv_den6_r [DIV_STAGES];
  logic [CNT_W-1:0] dv_rrem_r [DIV_STAGES];
  logic [HUE_W-1:0] dv_rq_r   [DIV_STAGES];
  logic [IDX_W-1:0] dv_rsh_r  [DIV_STAGES];
  logic [CB-1:0]    dv_hi_r   [DIV_STAGES];
  logic [CB-1:0]    dv_lo_r   [DIV_STAGES];
  logic [CB-1:0]    dv_c_r    [DIV_STAGES];
  logic [CB-1:0]    dv_v_r    [DIV_STAGES];

  logic             s_vld  [DIV_STAGES];
  logic [HR_W-1:0]  s_hrem [DIV_STAGES];
  logic [HUE_W-1:0] s_hq   [DIV_STAGES];
  logic [HR_W-1:0]  s_den6 [DIV_STAGES];
  logic [CNT_W-1:0] s_rrem [DIV_STAGES];
  logic [HUE_W-1:0] s_rq   [DIV_STAGES];
  logic [IDX_W-1:0] s_rsh  [DIV_STAGES];
  logic [CB-1:0]    s_hi   [DIV_STAGES];
  logic [CB-1:0]    s_lo   [DIV_STAGES];
  logic [CB-1:0]    s_c    [DIV_STAGES];
  logic [CB-1:0]    s_v    [DIV_STAGES];

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [HR_W-1:0]  hrem_nxt;
      logic [HUE_W-1:0] hq_nxt;
      logic [HR_W:0]    ht;
      logic [CNT_W-1:0] rrem_nxt;
      logic [HUE_W-1:0] rq_nxt;
      logic [IDX_W-1:0] rsh_nxt;
      logic [CNT_W:0]   rt;

      if (k == 0) begin : g_src0
        assign s_vld[k]  = a_vld_r;
        assign s_hrem[k] = a_num_r;
        assign s_hq[k]   = '0;
        assign s_den6[k] = a_den6_r;
        assign s_rrem[k] = '0;
        assign s_rq[k]   = '0;
        assign s_rsh[k]  = a_idx_r;
        assign s_hi[k]   = a_hi_r;
        assign s_lo[k]   = a_lo_r;
        assign s_c[k]    = a_c_r;
        assign s_v[k]    = a_v_r;
      end else begin : g_srcn
        assign s_vld[k]  = dv_vld_r[k-1];
        assign s_hrem[k] = dv_hrem_r[k-1];
        assign s_hq[k]   = dv_hq_r[k-1];
        assign s_den6[k] = dv_den6_r[k-1];
        assign s_rrem[k] = dv_rrem_r[k-1];
        assign s_rq[k]   = dv_rq_r[k-1];
        assign s_rsh[k]  = dv_rsh_r[k-1];
        assign s_hi[k]   = dv_hi_r[k-1];
        assign s_lo[k]   = dv_lo_r[k-1];
        assign s_c[k]    = dv_c_r[k-1];
        assign s_v[k]    = dv_v_r[k-1];
      end

      always_comb begin
        hrem_nxt = s_hrem[k];
        hq_nxt   = s_hq[k];
        ht       = '0;
        for (int s = 0; s < HUE_STEPS; s++) begin
          ht = {hrem_nxt, 1'b0};
          if (ht >= {1'b0, s_den6[k]}) begin
            ht     = ht - {1'b0, s_den6[k]};
            hq_nxt = {hq_nxt[HUE_W-2:0], 1'b1};
          end else begin
            hq_nxt = {hq_nxt[HUE_W-2:0], 1'b0};
          end
          hrem_nxt = ht[HR_W-1:0];
        end

        // dividend bits come from idx, then zeros
        rrem_nxt = s_rrem[k];
        rq_nxt   = s_rq[k];
        rsh_nxt  = s_rsh[k];
        rt       = '0;
        for (int s = 0; s < ROT_STEPS; s++) begin
          rt      = {rrem_nxt, rsh_nxt[IDX_W-1]};
          rsh_nxt = {rsh_nxt[IDX_W-2:0], 1'b0};
          if (rt >= {1'b0, count_e}) begin
            rt     = rt - {1'b0, count_e};
            rq_nxt = {rq_nxt[HUE_W-2:0], 1'b1};
          end else begin
            rq_nxt = {rq_nxt[HUE_W-2:0], 1'b0};
          end
          rrem_nxt = rt[CNT_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) dv_vld_r[k] <= 1'b0;
        else if (adv) dv_vld_r[k] <= s_vld[k];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_hrem_r[k] <= hrem_nxt;
          dv_hq_r[k]   <= hq_nxt;
          dv_den6_r[k] <= s_den6[k];
          dv_rrem_r[k] <= rrem_nxt;
          dv_rq_r[k]   <= rq_nxt;
          dv_rsh_r[k]  <= rsh_nxt;
          dv_hi_r[k]   <= s_hi[k];
          dv_lo_r[k]   <= s_lo[k];
          dv_c_r[k]    <= s_c[k];
          dv_v_r[k]    <= s_v[k];
        end
      end
    end
  endgenerate

  // ------------------------------------------- stage B: rotate, sector
  localparam int DL = DIV_STAGES - 1;

  logic [HUE_W-1:0] b_hue;
  logic [HUE_W+2:0] b_s6;

  assign b_hue = dv_hq_r[DL] + dv_rq_r[DL];   // wraps at one turn
  assign b_s6  = ((HUE_W+3)'(b_hue) << 2) + ((HUE_W+3)'(b_hue) << 1);

  logic             b_vld_r;
  logic [2:0]       b_face_r;
  logic [HUE_W-1:0] b_f_r;
  logic [CB-1:0]    b_hi_r, b_lo_r, b_c_r, b_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (adv) b_vld_r <= dv_vld_r[DL];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_face_r <= b_s6[HUE_W+2:HUE_W];
      b_f_r    <= b_s6[HUE_W-1:0];
      b_hi_r   <= dv_hi_r[DL];
      b_lo_r   <= dv_lo_r[DL];
      b_c_r    <= dv_c_r[DL];
      b_v_r    <= dv_v_r[DL];
    end
  end

  // ------------------------------------------- stage C: C*f, C*(1-f)
  logic [HUE_W:0]     c_g;
  logic [NX_W-1:0]    c_cf;
  logic [NX_W:0]      c_cf1;

  assign c_g   = (HUE_W+1)'(1 << HUE_W) - (HUE_W+1)'(b_f_r);
  assign c_cf  = NX_W'(b_c_r) * NX_W'(b_f_r);
  assign c_cf1 = (NX_W+1)'(b_c_r) * (NX_W+1)'(c_g);

  logic            c_vld_r;
  logic [NX_W-1:0] c_cf_r, c_cf1_r;
  logic [2:0]      c_face_r;
  logic [CB-1:0]   c_hi_r, c_lo_r, c_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (adv) c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_cf_r   <= c_cf;
      c_cf1_r  <= c_cf1[NX_W-1:0];   // never exceeds C << 16
      c_face_r <= b_face_r;
      c_hi_r   <= b_hi_r;
      c_lo_r   <= b_lo_r;
      c_v_r    <= b_v_r;
    end
  end

  // ------------------------------- stage D: numerators over hi << 16
  logic [NX_W-1:0] d_nx [LANES];
  logic [CB-1:0]   d_he;
  logic [NX_W-1:0] d_den;

  assign d_den = NX_W'(c_hi_r) << HUE_W;

  always_comb begin
    if (c_hi_r == '0) begin
      // black: saturation 0, every lane yields the value byte
      d_he = CB'(1);
      for (int l = 0; l < LANES; l++) d_nx[l] = NX_W'(1) << HUE_W;
    end else begin
      d_he         = c_hi_r;
      d_nx[LANE_P] = NX_W'(c_lo_r) << HUE_W;
      d_nx[LANE_Q] = d_den - c_cf_r;
      d_nx[LANE_T] = d_den - c_cf1_r;
      d_nx[LANE_V] = d_den;
    end
  end

  logic            d_vld_r;
  logic [NX_W-1:0] d_nx_r [LANES];
  logic [CB-1:0]   d_he_r, d_v_r;
  logic [2:0]      d_face_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (adv) d_vld_r <= c_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) d_nx_r[l] <= d_nx[l];
      d_he_r   <= d_he;
      d_v_r    <= c_v_r;
      d_face_r <= c_face_r;
    end
  end

  // ------------------------------------------------ stage E: v * num
  logic            e_vld_r;
  logic [PX_W-1:0] e_px_r [LANES];
  logic [CB-1:0]   e_he_r;
  logic [2:0]      e_face_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else if (adv) e_vld_r <= d_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) e_px_r[l] <= PX_W'(d_v_r) * PX_W'(d_nx_r[l]);
      e_he_r   <= d_he_r;
      e_face_r <= d_face_r;
    end
  end

  // ----------------------- stage F: byte rounding numerator and divisor
  // byte = floor((510*v*N + CMAX*D) / (2*CMAX*D)), D = he << 16
  logic [NW-1:0] f_cd;
  logic          f_vld_r;
  logic [NW-1:0] f_n_r [LANES];
  logic [NW-1:0] f_d_r;
  logic [2:0]    f_face_r;

  assign f_cd = (NW'(CMAX) * NW'(e_he_r)) << HUE_W;

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (adv) f_vld_r <= e_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) f_n_r[l] <= NW'(e_px_r[l]) * NW'(510) + f_cd;
      f_d_r    <= f_cd << 1;
      f_face_r <= e_face_r;
    end
  end

  // ---------------------------------------------- byte divider lanes
  logic [7:0] lane_byte [LANES];

  genvar ln;
  generate
    for (ln = 0; ln < LANES; ln++) begin : g_lane
      htint_bdiv #(
        .NW(NW)
      ) u_bdiv (
        .clk    (clk),
        .en     (adv),
        .n_i    (f_n_r[ln]),
        .d_i    (f_d_r),
        .byte_o (lane_byte[ln])
      );
    end
  endgenerate

  // valid and sector ride alongside the lanes
  logic       g_vld_r  [LANE_STAGES];
  logic [2:0] g_face_r [LANE_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_STAGES; i++) g_vld_r[i] <= 1'b0;
    end else if (adv) begin
      g_vld_r[0] <= f_vld_r;
      for (int i = 1; i < LANE_STAGES; i++) g_vld_r[i] <= g_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_face_r[0] <= f_face_r;
      for (int i = 1; i < LANE_STAGES; i++) g_face_r[i] <= g_face_r[i-1];
    end
  end

  // --------------------------------------------- sector pick, output
  logic [7:0] pb, qb, tb, vb;
  logic [23:0] rgb;

  assign pb = lane_byte[LANE_P];
  assign qb = lane_byte[LANE_Q];
  assign tb = lane_byte[LANE_T];
  assign vb = lane_byte[LANE_V];

  always_comb begin
    case (g_face_r[LANE_STAGES-1])
      SECT_RED_YEL: rgb = {vb, tb, pb};
      SECT_YEL_GRN: rgb = {qb, vb, pb};
      SECT_GRN_CYN: rgb = {pb, vb, tb};
      SECT_CYN_BLU: rgb = {pb, qb, vb};
      SECT_BLU_MAG: rgb = {tb, pb, vb};
      default:      rgb = {vb, pb, qb};
    endcase
  end

  logic [23:0] out_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= g_vld_r[LANE_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (adv) out_rgb_r <= rgb;
  end

  assign out_valid      = out_vld_r;
  assign out_packed_rgb = out_rgb_r;

  // --------------------------------------------------------- checks
  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[DL] |-> (dv_hrem_r[DL] < dv_den6_r[DL]))
    else $error("hue remainder out of range");

  a_rot_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[DL] |-> (dv_rrem_r[DL] < count_e))
    else $error("rotation remainder out of range");

  a_face: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> (b_face_r <= SECT_BLU_MAG + 3'd1))
    else $error("hue sector above five");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== sim/tint_checker.sv =====
module tint_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [11:0] in_accent_red,
  input  logic [11:0] in_accent_green,
  input  logic [11:0] in_accent_blue,
  input  logic [7:0]  in_tint_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [23:0] out_packed_rgb,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import htint_pkg::*;

  localparam int CMAX = 4095;

  logic [4:0]  tint_count_q;
  logic [11:0] value_floor_q;
  logic [23:0] expected_rgb[$];
  int          mismatch_count;

  function automatic logic [7:0] channel_byte(longint unsigned v, longint unsigned num,
                                              longint unsigned den);
    longint unsigned n, d, b;
    n = 2 * 255 * v * num + CMAX * den;
    d = 2 * CMAX * den;
    b = n / d;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  function automatic logic [23:0] predict_rgb(logic [11:0] r, logic [11:0] g,
                                              logic [11:0] b, logic [7:0] idx);
    longint unsigned hi, lo, chroma, hue, count, rot, v, flr, s6, face, f, den;
    longint signed   num;
    logic [7:0] vb, pb, qb, tb, rb, gb, bb;
    hi = (r > g) ? 64'(r) : 64'(g);
    lo = (r < g) ? 64'(r) : 64'(g);
    if (64'(b) > hi) hi = 64'(b);
    if (64'(b) < lo) lo = 64'(b);
    chroma = hi - lo;
    hue = 0;
    if (chroma > 0) begin
      if (hi == 64'(r)) begin
        num = longint'(g) - longint'(b);
        if (num < 0) num += 6 * longint'(chroma);
      end else if (hi == 64'(g)) begin
        num = longint'(b) - longint'(r) + 2 * longint'(chroma);
      end else begin
        num = longint'(r) - longint'(g) + 4 * longint'(chroma);
      end
      hue = ((unsigned'(num) * 65536) / (6 * chroma)) & 64'hFFFF;
    end
    count = (tint_count_q == 0) ? 1 : 64'(tint_count_q);
    rot = ((64'(idx) % count) * 65536) / count;
    hue = (hue + rot) & 64'hFFFF;
    flr = 64'(value_floor_q);
    v = (hi > flr) ? hi : flr;
    s6 = hue * 6;
    face = s6 >> 16;
    f = s6 & 64'hFFFF;
    vb = channel_byte(v, 1, 1);
    if (hi == 0) begin
      pb = vb; qb = vb; tb = vb;
    end else begin
      den = hi * 65536;
      pb = channel_byte(v, lo, hi);
      qb = channel_byte(v, den - chroma * f, den);
      tb = channel_byte(v, den - chroma * (65536 - f), den);
    end
    case (face)
      0: begin rb = vb; gb = tb; bb = pb; end
      1: begin rb = qb; gb = vb; bb = pb; end
      2: begin rb = pb; gb = vb; bb = tb; end
      3: begin rb = pb; gb = qb; bb = vb; end
      4: begin rb = tb; gb = pb; bb = vb; end
      default: begin rb = vb; gb = pb; bb = qb; end
    endcase
    return {rb, gb, bb};
  endfunction

  assign pending = expected_rgb.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      tint_count_q <= 5'd3;
      value_floor_q <= 12'd3481;
      fail_count <= 0;
      mismatch_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TINT_COUNT) tint_count_q <= cfg_wdata[4:0];
        else value_floor_q <= cfg_wdata;
      end
      if (in_valid && in_ready)
        expected_rgb.push_back(predict_rgb(in_accent_red, in_accent_green, in_accent_blue,
                                           in_tint_index));
      if (out_valid && out_ready) begin
        if (expected_rgb.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatch_count < 10) $display("unexpected beat %06h", out_packed_rgb);
          mismatch_count <= mismatch_count + 1;
        end else begin
          if (expected_rgb[0] !== out_packed_rgb) begin
            fail_count <= fail_count + 1;
            if (mismatch_count < 10)
              $display("rgb mismatch: exp %06h got %06h", expected_rgb[0], out_packed_rgb);
            mismatch_count <= mismatch_count + 1;
          end
          void'(expected_rgb.pop_front());
        end
      end
    end
  end
endmodule

// ===== sim/tb.sv =====
module tb;
  import htint_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [11:0] in_accent_red = 0, in_accent_green = 0, in_accent_blue = 0;
  logic [7:0]  in_tint_index = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [23:0] out_packed_rgb;
  logic        cfg_we = 0;
  logic        cfg_index = REG_TINT_COUNT;
  logic [11:0] cfg_wdata = 0;
  int          fail_count, pending;
  bit          drain_on = 0;

  hue_rotated_tint dut (.*);

  tint_checker chk (.*);

  initial forever #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one beat; valid stays up across back-to-back beats
  task automatic send_beat(logic [11:0] r, logic [11:0] g, logic [11:0] b, logic [7:0] idx);
    in_valid <= 1;
    in_accent_red <= r;
    in_accent_green <= g;
    in_accent_blue <= b;
    in_tint_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (gap_len()) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  // one write, then cfg_we drops so back-to-back writes never collide
  task automatic write_reg(logic idx, logic [11:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // config only changes with the pipe empty
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_colors(int n);
    logic [11:0] r, g, b;
    int mode;
    repeat (n) begin
      mode = $urandom_range(0, 9);
      r = 12'($urandom); g = 12'($urandom); b = 12'($urandom);
      if (mode == 0) begin g = r; b = r; end              // grey
      else if (mode == 1) begin r = 12'($urandom_range(0, 3)); g = r; b = 0; end
      else if (mode == 2) b = g;                           // green equals blue, a tie on max when above red
      send_beat(r, g, b, 8'($urandom));
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (drain_on) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 1) == 1);
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset defaults: count 3, floor 3481
    send_beat(0, 0, 0, 0);
    send_beat(12'hFFF, 12'hFFF, 12'hFFF, 8'hFF);
    send_beat(12'hFFF, 0, 0, 1);
    send_beat(0, 12'hFFF, 0, 2);
    send_beat(0, 0, 12'hFFF, 3);
    send_beat(12'hFFF, 0, 12'h800, 4);
    send_beat(12'h123, 12'h123, 12'h123, 5);
    send_beat(1, 0, 0, 8'h80);
    settle();
    write_reg(REG_TINT_COUNT, 0);      // zero count acts as one
    write_reg(REG_VALUE_FLOOR, 0);
    send_beat(12'hFFF, 12'h400, 0, 8'hFF);
    send_beat(0, 0, 0, 7);
    send_beat(12'h010, 12'h020, 12'h030, 8'h55);
    send_beat(12'hAAA, 12'h555, 12'hFFF, 8'hAA);
    settle();
    write_reg(REG_TINT_COUNT, 31);     // above 16, used as given
    write_reg(REG_VALUE_FLOOR, 12'hFFF);
    send_beat(12'hFFF, 12'h800, 0, 30);
    send_beat(12'h001, 12'h000, 12'h002, 8'hFF);
    send_beat(12'h7FF, 12'h7FF, 0, 29);
    settle();
    write_reg(REG_TINT_COUNT, 16);
    write_reg(REG_VALUE_FLOOR, 3481);
    random_colors(150);
    settle();
    write_reg(REG_TINT_COUNT, 1);
    write_reg(REG_VALUE_FLOOR, 0);
    random_colors(150);
    settle();
    write_reg(REG_TINT_COUNT, 12'($urandom));
    write_reg(REG_VALUE_FLOOR, 12'($urandom));
    random_colors(150);
    settle();
    write_reg(REG_TINT_COUNT, 12'd7);
    write_reg(REG_VALUE_FLOOR, 12'hFFF);
    random_colors(150);
    in_valid <= 0;
    drain_on = 1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule

// ===== hue_rotated_tint.f =====
hdl/htint_pkg.sv
hdl/htint_bdiv.sv
hdl/hue_rotated_tint.sv
sim/tint_checker.sv
sim/tb.sv
